@@ design/sign_flag_varint_decoder_core_assert.svh @@
// assertion macros used by the checker module of the varint decoder
`ifndef SIGN_FLAG_VARINT_DECODER_CORE_ASSERT_SVH
`define SIGN_FLAG_VARINT_DECODER_CORE_ASSERT_SVH

// clocked assertion, masked while reset is asserted
`define SFVD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds across reset
`define SFVD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sfvd_pkg.sv @@
// types, constants and helper functions of the signed-flag varint decoder
package sfvd_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned IdxW   = 3;

    localparam logic [7:0] PAYLOAD0_MASK = 8'h3F;
    localparam logic [7:0] PAYLOAD_MASK  = 8'h7F;
    localparam int unsigned SIGN_POS     = 6;
    localparam int unsigned MORE_POS     = 7;

    localparam logic [ValueW-1:0] FILL_SHORT   = 32'hFFFF_FFC0;
    localparam logic [ValueW-1:0] FILL_STAGE12 = 32'hFFFF_E000;
    localparam logic [ValueW-1:0] FILL_STAGE3  = 32'hFFF0_0000;
    localparam logic [ValueW-1:0] FILL_STAGE4  = 32'hF800_0000;
    localparam logic [ValueW-1:0] TOP_BIT      = 32'h8000_0000;
    localparam logic [ValueW-1:0] LOW27_MASK   = 32'h07FF_FFFF;

    // byte_index codes
    localparam logic [IdxW-1:0] IDX_IDLE = 3'd0;
    localparam logic [IdxW-1:0] IDX_B1   = 3'd1;
    localparam logic [IdxW-1:0] IDX_B2   = 3'd2;
    localparam logic [IdxW-1:0] IDX_B3   = 3'd3;
    localparam logic [IdxW-1:0] IDX_B4   = 3'd4;

    typedef struct packed {
        logic [ValueW-1:0] partial_value;
        logic [IdxW-1:0]   byte_index;
        logic              negative_flag;
    } t_state;

    typedef struct packed {
        logic              emit;
        logic [ValueW-1:0] value;
        logic              truncated;
    } t_result;

    // ones above the payload for a negative value, by stage reached
    function automatic logic [ValueW-1:0] stage_fill(input logic [IdxW-1:0] idx);
        logic [ValueW-1:0] fill;
        fill = FILL_STAGE12;
        if (idx >= IDX_B4) begin
            fill = FILL_STAGE4;
        end else if (idx == IDX_B3) begin
            fill = FILL_STAGE3;
        end
        return fill;
    endfunction

    // bit offset of the payload of a continuation byte
    function automatic logic [4:0] payload_shift(input logic [IdxW-1:0] idx);
        logic [4:0] sh;
        case (idx)
            IDX_B1:  sh = 5'd6;
            IDX_B2:  sh = 5'd13;
            IDX_B3:  sh = 5'd20;
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

endpackage

@@ design/sfvd_in_stage.sv @@
// input register of the varint decoder: holds one byte transfer
module sfvd_in_stage
    import sfvd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_valid,
    input  logic [7:0] i_byte_in,
    input  logic       i_buffer_end,
    output logic       o_valid,
    output logic [7:0] o_byte_in,
    output logic       o_buffer_end
);

    logic       r_valid;
    logic [7:0] r_byte_in;
    logic       r_buffer_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_byte_in    <= i_byte_in;
            r_buffer_end <= i_buffer_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte_in    = r_byte_in;
    assign o_buffer_end = r_buffer_end;

endmodule

@@ design/sfvd_step.sv @@
// combinational decode of one byte against the current decoder state
module sfvd_step
    import sfvd_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte_in,
    input  logic       i_buffer_end,
    output t_state     o_next_state,
    output t_result    o_result
);

    logic [ValueW-1:0] merged;
    logic [ValueW-1:0] payload;
    logic              more;

    assign more    = i_byte_in[MORE_POS];
    assign payload = {{(ValueW-8){1'b0}}, i_byte_in & PAYLOAD_MASK};
    assign merged  = i_state.partial_value | (payload << payload_shift(i_state.byte_index));

    always_comb begin
        o_next_state     = i_state;
        o_result.emit      = 1'b0;
        o_result.value     = '0;
        o_result.truncated = 1'b0;

        if (i_buffer_end) begin
            o_result.emit      = 1'b1;
            o_result.truncated = 1'b1;
            case (i_state.byte_index) inside
                [IDX_B1:IDX_B4]: begin
                    o_result.value = i_state.partial_value
                                   | (i_state.negative_flag ?
                                      stage_fill(i_state.byte_index) : '0);
                end
                default: begin
                    o_result.value = '0;
                end
            endcase
        end else begin
            case (i_state.byte_index) inside
                [IDX_B1:IDX_B3]: begin
                    o_next_state.partial_value = merged;
                    if (more) begin
                        o_next_state.byte_index = i_state.byte_index + IdxW'(1);
                    end else begin
                        o_result.emit  = 1'b1;
                        o_result.value = merged
                                       | (i_state.negative_flag ?
                                          stage_fill(i_state.byte_index + IdxW'(1)) : '0);
                    end
                end
                IDX_B4: begin
                    o_result.emit  = 1'b1;
                    o_result.value = (i_state.partial_value & LOW27_MASK)
                                   | {i_byte_in[4:0], 27'b0}
                                   | (i_state.negative_flag ? TOP_BIT : '0);
                end
                default: begin
                    // first byte of a value; stray indexes count as idle
                    o_next_state.partial_value = {{(ValueW-8){1'b0}},
                                                  i_byte_in & PAYLOAD0_MASK};
                    o_next_state.negative_flag = i_byte_in[SIGN_POS];
                    o_next_state.byte_index    = IDX_B1;
                    if (!more) begin
                        o_result.emit  = 1'b1;
                        o_result.value = i_byte_in[SIGN_POS] ?
                                         ({{(ValueW-8){1'b0}}, i_byte_in} | FILL_SHORT) :
                                         {{(ValueW-8){1'b0}}, i_byte_in & PAYLOAD0_MASK};
                    end
                end
            endcase
        end

        // a finished value leaves the decoder idle
        if (o_result.emit) begin
            o_next_state = '0;
        end
    end

endmodule

@@ design/sign_flag_varint_decoder_core.sv @@
// Signed-flag varint decoder, 32-bit. Takes one stream byte per clock and emits one decoded
// value per finished varint; an end-of-buffer transfer flushes any partial value with the
// truncated flag (zero if nothing is in progress). Throughput is one byte per cycle while the
// input is not stalled: the merge of a byte into the running value is combinational logic
// between the input register and the result register. A byte is held in the input register,
// and its result is loaded into the result register, which offers it to the consumer. The
// input stalls only while the held byte finishes a value, the result register is still full
// and the consumer holds i_stall high. No clearing pass after reset.
module sign_flag_varint_decoder_core
    import sfvd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_byte_in,
    input  logic                     i_buffer_end,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [ValueW-1:0] o_value,
    output logic                     o_truncated
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_end;
    logic       advance;

    t_state  r_state;
    t_state  n_state;
    t_result step_res;

    logic              r_out_valid;
    logic [ValueW-1:0] r_value;
    logic              r_truncated;

    // the held byte moves on unless it makes a result and the result slot stays full
    assign advance = !in_valid || !step_res.emit || !r_out_valid || !i_stall;
    assign o_stall = !advance;

    sfvd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance),
        .i_valid      (i_valid),
        .i_byte_in    (i_byte_in),
        .i_buffer_end (i_buffer_end),
        .o_valid      (in_valid),
        .o_byte_in    (in_byte),
        .o_buffer_end (in_end)
    );

    sfvd_step u_step (
        .i_state      (r_state),
        .i_byte_in    (in_byte),
        .i_buffer_end (in_end),
        .o_next_state (n_state),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_valid && advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_valid && advance && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_valid && advance && step_res.emit) begin
            r_value     <= step_res.value;
            r_truncated <= step_res.truncated;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = $signed(r_value);
    assign o_truncated = r_truncated;

endmodule

@@ design/sfvd_checker.sv @@
// port-level checker for the varint decoder, bound to the top level
`include "sign_flag_varint_decoder_core_assert.svh"

module sfvd_checker
    import sfvd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [ValueW-1:0] o_value,
    input logic                     o_truncated
);

    logic            out_wait;
    logic [ValueW:0] out_word;

    assign out_wait = o_valid && i_stall;
    assign out_word = {o_value, o_truncated};

    // a stalled result stays offered
    `SFVD_ASSERT(a_out_hold_valid, i_clk, i_rst_n, out_wait |=> o_valid, "stalled result dropped")

    // a stalled result keeps its payload
    `SFVD_ASSERT(a_hold_data, i_clk, i_rst_n, out_wait |=> $stable(out_word), "result changed")

    // input only backs up behind a full result register
    `SFVD_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> out_wait, "needless input stall")

    // reset empties the result register
    `SFVD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

bind sign_flag_varint_decoder_core sfvd_checker u_sfvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_value     (o_value),
    .o_truncated (o_truncated)
);

@@ verif/testbench.sv @@
// self-checking testbench for the signed-flag varint decoder core
module testbench;
    import sfvd_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        logic [ValueW-1:0] value;
        logic              truncated;
    } t_decoded;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [7:0]               i_byte_in;
    logic                     i_buffer_end;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [ValueW-1:0] o_value;
    logic                     o_truncated;

    // shadow copy of the decoder state
    logic [ValueW-1:0] shadow_value;
    logic [IdxW-1:0]   shadow_stage;
    logic              shadow_negative;

    t_decoded pending_values[$];
    int       failures;
    int       items_sent;
    bit       steady_flow;

    sign_flag_varint_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_in    (i_byte_in),
        .i_buffer_end (i_buffer_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_truncated  (o_truncated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ones above the gathered payload of a negative value, by stage reached
    function automatic logic [ValueW-1:0] sign_extension(input logic [IdxW-1:0] stage);
        logic [ValueW-1:0] fill;
        case (stage)
            IDX_B3:  fill = FILL_STAGE3;
            IDX_B4:  fill = FILL_STAGE4;
            default: fill = FILL_STAGE12;
        endcase
        return fill;
    endfunction

    task automatic decode_varint_byte(input logic [7:0] b, input logic last);
        t_decoded          r;
        logic [ValueW-1:0] v;
        logic              done;
        int                shift;
        done        = 1'b0;
        v           = '0;
        r.truncated = last;
        if (last) begin
            done = 1'b1;
            if (shadow_stage != IDX_IDLE) begin
                v = shadow_value;
                if (shadow_negative) v = v | sign_extension(shadow_stage);
            end
        end else begin
            case (shadow_stage)
                IDX_IDLE: begin
                    shadow_value    = {24'b0, b & PAYLOAD0_MASK};
                    shadow_negative = b[SIGN_POS];
                    if (b[MORE_POS]) begin
                        shadow_stage = IDX_B1;
                    end else begin
                        v    = shadow_negative ? ({24'b0, b} | FILL_SHORT) : shadow_value;
                        done = 1'b1;
                    end
                end
                IDX_B4: begin
                    // fifth byte: low five bits land on top, the rest drop out
                    v = (shadow_value & LOW27_MASK) | {b[4:0], 27'b0};
                    if (shadow_negative) v = v | TOP_BIT;
                    done = 1'b1;
                end
                default: begin
                    shift        = 7 * int'(shadow_stage) - 1;
                    shadow_value = shadow_value | ({25'b0, b[6:0]} << shift);
                    if (b[MORE_POS]) begin
                        shadow_stage = shadow_stage + IdxW'(1);
                    end else begin
                        v = shadow_value;
                        if (shadow_negative) v = v | sign_extension(shadow_stage + IdxW'(1));
                        done = 1'b1;
                    end
                end
            endcase
        end
        if (done) begin
            r.value = v;
            pending_values.insert(pending_values.size(), r);
            shadow_value    = '0;
            shadow_stage    = IDX_IDLE;
            shadow_negative = 1'b0;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_in    <= b;
        i_buffer_end <= last;
        do @(posedge i_clk); while (o_stall);
        decode_varint_byte(b, last);
        items_sent++;
    endtask

    // random content, continuation bits set so the value spans len bytes;
    // cut leaves it open and closes the buffer instead
    task automatic send_varint(input int len, input bit cut);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i < 4) b[MORE_POS] = cut || (i < len - 1);
            send_item(b, 1'b0);
        end
        if (cut) send_item(8'($urandom), 1'b1);
    endtask

    task automatic wait_for_drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_values.size() != 0);
    endtask

    task automatic test_single_byte;
        send_item(8'h00, 1'b0);
        send_item(8'h3F, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'h7F, 1'b0);
    endtask

    task automatic test_end_without_value;
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_long_values;
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b0);
        // all payload bits set with the sign flag clear, top bits of the fifth byte set and dropped
        send_item(8'hBF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        // negative with empty payload, five bytes
        send_item(8'hC0, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
    endtask

    task automatic test_truncation;
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_random_stream;
        int kind;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady_flow = ((sent / 100) % 4) == 3;
            kind        = $urandom_range(0, 99);
            if (kind < 74) begin
                send_varint($urandom_range(1, 5), 1'b0);
            end else if (kind < 88) begin
                send_varint($urandom_range(1, 4), 1'b1);
            end else if (kind < 94) begin
                send_item(8'($urandom), 1'b1);
            end else begin
                send_item(8'($urandom), 1'b0);
            end
            if ($urandom_range(0, 199) == 0) wait_for_drain();
            sent = items_sent;
        end
        steady_flow = 1'b0;
    endtask

    // receiver side: random stall before each result
    initial begin : result_backpressure
        int hold;
        forever begin
            hold = steady_flow ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_valid));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result: value %h truncated %b", o_value, o_truncated);
                failures++;
            end else begin
                want = pending_values.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, o_value);
                    failures++;
                end
                if (o_truncated !== want.truncated) begin
                    $error("truncated: expected %b, actual %b", want.truncated, o_truncated);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        failures        = 0;
        items_sent      = 0;
        steady_flow     = 1'b0;
        shadow_value    = '0;
        shadow_stage    = IDX_IDLE;
        shadow_negative = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_byte_in    <= 8'h00;
        i_buffer_end <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_byte();
        test_end_without_value();
        test_long_values();
        test_truncation();
        wait_for_drain();
        test_random_stream();

        wait_for_drain();
        repeat (6) @(posedge i_clk);
        if (failures == 0 && pending_values.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
